>>> src/idlrq_pkg.sv
// Shared types and constants for the indexed doubly linked ready queue.
package idlrq_pkg;

  localparam int MAX_PROCS_DEF = 64;
  localparam int ID_W          = 6;
  localparam int STATUS_W      = 2;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_DUP_APPEND = 2'd1,
    ST_NOT_QUEUED = 2'd2,
    ST_RANGE      = 2'd3
  } status_e;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] head_id;
    logic [ID_W-1:0] tail_id;
    logic            queue_empty;
  } result_t;

endpackage

>>> src/indexed_doubly_linked_ready_queue.sv
// Ready queue top: input stage, link RAMs with write bypass, list core, result register.
// An accepted beat is registered in the input stage; the result register loads when the
// beat is processed, which waits while a result is held by the stalled receiver.
// One beat per cycle unless stalled; link RAMs take one read and one write each cycle.
// Reset: membership bits cleared, head and tail zero, queue empty, pipeline empty.
// The link RAMs are not cleared; an entry is written before its read value is ever used.
module indexed_doubly_linked_ready_queue #(
  parameter int MAX_PROCS = idlrq_pkg::MAX_PROCS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [idlrq_pkg::ID_W-1:0]     proc_id_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [idlrq_pkg::STATUS_W-1:0] status_o,
  output logic [idlrq_pkg::ID_W-1:0]     head_id_o,
  output logic [idlrq_pkg::ID_W-1:0]     tail_id_o,
  output logic                           queue_empty_o
);
  import idlrq_pkg::*;

  localparam int NUM_SLOTS = (MAX_PROCS < (2 ** ID_W)) ? MAX_PROCS : (2 ** ID_W);
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  logic             accept, fire;
  logic             s1_valid_q, s1_valid_d;
  opcode_e          s1_op_q;
  logic [ID_W-1:0]  s1_id_q;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res;
  link_wr_t         next_wr, prev_wr;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] next_ram, prev_ram, next_rd, prev_rd;
  logic             nfwd_q, pfwd_q;
  logic [IDX_W-1:0] nfwd_data_q, pfwd_data_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign raddr      = proc_id_i[IDX_W-1:0];

  idlrq_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_wr.en),
    .waddr_i (next_wr.addr[IDX_W-1:0]),
    .wdata_i (next_wr.data[IDX_W-1:0]),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (next_ram)
  );

  idlrq_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_wr.en),
    .waddr_i (prev_wr.addr[IDX_W-1:0]),
    .wdata_i (prev_wr.data[IDX_W-1:0]),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (prev_ram)
  );

  // a write landing on the same edge as the read is missed by the RAM; forward it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfwd_q <= 1'b0;
      pfwd_q <= 1'b0;
    end else if (accept) begin
      nfwd_q <= next_wr.en && (next_wr.addr[IDX_W-1:0] == raddr);
      pfwd_q <= prev_wr.en && (prev_wr.addr[IDX_W-1:0] == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nfwd_data_q <= next_wr.data[IDX_W-1:0];
      pfwd_data_q <= prev_wr.data[IDX_W-1:0];
      s1_op_q     <= opcode_e'(opcode_i);
      s1_id_q     <= proc_id_i;
    end
  end

  assign next_rd = nfwd_q ? nfwd_data_q : next_ram;
  assign prev_rd = pfwd_q ? pfwd_data_q : prev_ram;

  idlrq_core #(.MAX_PROCS(MAX_PROCS), .NUM_SLOTS(NUM_SLOTS), .IDX_W(IDX_W)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .opcode_i  (s1_op_q),
    .proc_id_i (s1_id_q),
    .next_rd_i (next_rd),
    .prev_rd_i (prev_rd),
    .res_o     (res),
    .next_wr_o (next_wr),
    .prev_wr_o (prev_wr)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign head_id_o     = res_q.head_id;
  assign tail_id_o     = res_q.tail_id;
  assign queue_empty_o = res_q.queue_empty;

  // input stalls only while the stage is full and the result register is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // a processed beat shows up as a result on the next cycle
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed beat produced no result");

  // an empty queue reports zero head and tail
  a_empty_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && queue_empty_o) |-> (head_id_o == '0 && tail_id_o == '0))
    else $error("empty queue with nonzero head or tail");

  // link writes happen only on a processed beat
  a_wr_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_wr.en || prev_wr.en) |-> fire)
    else $error("link write without a processed beat");

endmodule

>>> src/idlrq_ram.sv
// Generic single write port RAM with registered read.
module idlrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/idlrq_core.sv
// Queue state (head, tail, empty, membership) and the per-beat list update.
module idlrq_core #(
  parameter int MAX_PROCS = idlrq_pkg::MAX_PROCS_DEF,
  parameter int NUM_SLOTS = idlrq_pkg::MAX_PROCS_DEF,
  parameter int IDX_W     = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  idlrq_pkg::opcode_e          opcode_i,
  input  logic [idlrq_pkg::ID_W-1:0]  proc_id_i,
  input  logic [IDX_W-1:0]            next_rd_i,
  input  logic [IDX_W-1:0]            prev_rd_i,
  output idlrq_pkg::result_t          res_o,
  output idlrq_pkg::link_wr_t         next_wr_o,
  output idlrq_pkg::link_wr_t         prev_wr_o
);
  import idlrq_pkg::*;

  logic [IDX_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]     tail_q, tail_d;
  logic                 empty_q, empty_d;
  logic [NUM_SLOTS-1:0] iq_q, iq_d;

  logic [IDX_W-1:0] pidx;
  logic             range_ok;
  logic             queued;
  status_e          status;

  assign pidx     = proc_id_i[IDX_W-1:0];
  assign range_ok = 32'(proc_id_i) < 32'(MAX_PROCS);
  assign queued   = range_ok && iq_q[pidx];

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    iq_d      = iq_q;
    status    = ST_DONE;
    next_wr_o = '0;
    prev_wr_o = '0;
    if (!range_ok) begin
      status = ST_RANGE;
    end else if (opcode_i == OP_APPEND) begin
      if (queued) begin
        status = ST_DUP_APPEND;
      end else begin
        iq_d[pidx] = 1'b1;
        tail_d     = pidx;
        if (empty_q) begin
          head_d  = pidx;
          empty_d = 1'b0;
        end else begin
          // link old tail forward and new entry back
          next_wr_o = '{en: fire_i, addr: ID_W'(tail_q), data: ID_W'(pidx)};
          prev_wr_o = '{en: fire_i, addr: ID_W'(pidx), data: ID_W'(tail_q)};
        end
      end
    end else begin
      if (!queued) begin
        status = ST_NOT_QUEUED;
      end else begin
        iq_d[pidx] = 1'b0;
        if (pidx == head_q) begin
          if (pidx == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = next_rd_i;
          end
        end else if (pidx == tail_q) begin
          tail_d = prev_rd_i;
        end else begin
          // splice the neighbors around the middle entry
          next_wr_o = '{en: fire_i, addr: ID_W'(prev_rd_i), data: ID_W'(next_rd_i)};
          prev_wr_o = '{en: fire_i, addr: ID_W'(next_rd_i), data: ID_W'(prev_rd_i)};
        end
      end
    end
  end

  always_comb begin
    res_o.status      = status;
    res_o.head_id     = empty_d ? '0 : ID_W'(head_d);
    res_o.tail_id     = empty_d ? '0 : ID_W'(tail_d);
    res_o.queue_empty = empty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      iq_q    <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      iq_q    <= iq_d;
    end
  end

endmodule

>>> verif/ready_queue_checker.sv
`timescale 1ns / 1ps
// Checker for the ready queue: watches both channels, predicts each result and compares it.
module ready_queue_checker #(
  parameter int MAX_PROCS = idlrq_pkg::MAX_PROCS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic                           opcode_i,
  input  logic [idlrq_pkg::ID_W-1:0]     proc_id_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [idlrq_pkg::STATUS_W-1:0] status_i,
  input  logic [idlrq_pkg::ID_W-1:0]     head_id_i,
  input  logic [idlrq_pkg::ID_W-1:0]     tail_id_i,
  input  logic                           queue_empty_i,
  output int                             fail_count_o,
  output int                             outstanding_o,
  output int                             checked_o
);
  import idlrq_pkg::*;

  // Shadow of the linked list.
  logic [ID_W-1:0] succ [MAX_PROCS];
  logic [ID_W-1:0] pred [MAX_PROCS];
  bit              linked [MAX_PROCS];
  logic [ID_W-1:0] head_q;
  logic [ID_W-1:0] tail_q;
  bit              empty_q;

  result_t expected_results [$];
  int      errors  = 0;
  int      checked = 0;
  int      waiting = 0;

  assign fail_count_o  = errors;
  assign outstanding_o = waiting;
  assign checked_o     = checked;

  task automatic step_ready_list(input opcode_e op, input logic [ID_W-1:0] id,
                                 output result_t res);
    status_e st;
    if (int'(id) >= MAX_PROCS) begin
      st = ST_RANGE;
    end else if (op == OP_APPEND) begin
      if (linked[id]) begin
        st = ST_DUP_APPEND;
      end else begin
        if (empty_q) begin
          head_q  = id;
          tail_q  = id;
          empty_q = 1'b0;
        end else begin
          succ[tail_q] = id;
          pred[id]     = tail_q;
          tail_q       = id;
        end
        linked[id] = 1'b1;
        st = ST_DONE;
      end
    end else begin
      if (!linked[id]) begin
        st = ST_NOT_QUEUED;
      end else begin
        if (id == head_q) begin
          if (id == tail_q) begin
            head_q  = '0;
            tail_q  = '0;
            empty_q = 1'b1;
          end else begin
            head_q = succ[id];
          end
        end else if (id == tail_q) begin
          tail_q = pred[id];
        end else begin
          // Unlink from the middle: bridge the two neighbors.
          succ[pred[id]] = succ[id];
          pred[succ[id]] = pred[id];
        end
        linked[id] = 1'b0;
        st = ST_DONE;
      end
    end
    res.status      = st;
    res.head_id     = empty_q ? '0 : head_q;
    res.tail_id     = empty_q ? '0 : tail_q;
    res.queue_empty = empty_q;
  endtask

  task automatic flag_mismatch(input bit have_want, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      if (have_want) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  expected status %0d head %0d tail %0d empty %0d",
                 want.status, want.head_id, want.tail_id, want.queue_empty);
        $display("  actual   status %0d head %0d tail %0d empty %0d",
                 got.status, got.head_id, got.tail_id, got.queue_empty);
      end else begin
        $display("[%0t] unexpected result beat: status %0d head %0d tail %0d empty %0d",
                 $realtime, got.status, got.head_id, got.tail_id, got.queue_empty);
      end
    end
  endtask

  always @(posedge clk_i) begin : watch
    result_t got;
    result_t want;
    result_t res;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCS; i++) linked[i] = 1'b0;
      head_q  = '0;
      tail_q  = '0;
      empty_q = 1'b1;
      expected_results.delete();
    end else begin
      // Compare before pushing: a result never belongs to the beat accepted at this edge.
      if (out_valid_i && !out_stall_i) begin
        got.status      = status_e'(status_i);
        got.head_id     = head_id_i;
        got.tail_id     = tail_id_i;
        got.queue_empty = queue_empty_i;
        if (expected_results.size() == 0) begin
          flag_mismatch(1'b0, '0, got);
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (got.status != want.status || got.head_id != want.head_id ||
              got.tail_id != want.tail_id || got.queue_empty != want.queue_empty)
            flag_mismatch(1'b1, want, got);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_ready_list(opcode_e'(opcode_i), proc_id_i, res);
        expected_results.push_back(res);
      end
    end
    waiting = expected_results.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the ready queue: reset, stimulus, idling, watchdog and verdict.
module tb;
  import idlrq_pkg::*;

  localparam int NPROC      = MAX_PROCS_DEF;
  localparam int IDLE_LIMIT = 1000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                opcode    = 1'b0;
  logic [ID_W-1:0]     proc_id   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     head_id;
  logic [ID_W-1:0]     tail_id;
  logic                queue_empty;

  int fail_count;
  int outstanding;
  int checked;

  // Membership as the stimulus sees it, to steer toward well-formed operations.
  bit [NPROC-1:0] queued = '0;
  int depth      = 0;
  int peak_depth = 0;
  int beats      = 0;
  bit calm       = 1'b0;
  int gap_odds   = 20;
  int stall_odds = 20;

  always #5 clk = ~clk;

  indexed_doubly_linked_ready_queue dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .proc_id_i    (proc_id),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .head_id_o    (head_id),
    .tail_id_o    (tail_id),
    .queue_empty_o(queue_empty)
  );

  ready_queue_checker #(.MAX_PROCS(NPROC)) queue_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .opcode_i     (opcode),
    .proc_id_i    (proc_id),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .status_i     (status),
    .head_id_i    (head_id),
    .tail_id_i    (tail_id),
    .queue_empty_i(queue_empty),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .checked_o    (checked)
  );

  function automatic logic [ID_W-1:0] any_queued_id();
    int id;
    do id = $urandom_range(0, NPROC - 1); while (!queued[id]);
    return id[ID_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] any_free_id();
    int id;
    do id = $urandom_range(0, NPROC - 1); while (queued[id]);
    return id[ID_W-1:0];
  endfunction

  task automatic send_beat(input opcode_e op, input logic [ID_W-1:0] id);
    int gap;
    gap = (!calm && gap_odds > 0 && $urandom_range(1, 100) <= gap_odds) ?
          $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    proc_id  <= id;
    do @(posedge clk); while (in_stall);
    beats++;
    if (op == OP_APPEND && !queued[id]) begin
      queued[id] = 1'b1;
      depth++;
    end else if (op == OP_REMOVE && queued[id]) begin
      queued[id] = 1'b0;
      depth--;
    end
    if (depth > peak_depth) peak_depth = depth;
  endtask

  // Hold off the sender until every expected result is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly legal operations steered toward a target depth, plus duplicates,
  // removals of absent slots and raw noise.
  task automatic random_beat(input int target);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12 && depth > 0)
      send_beat(OP_APPEND, any_queued_id());
    else if (roll < 24 && depth < NPROC)
      send_beat(OP_REMOVE, any_free_id());
    else if (roll < 28)
      send_beat(opcode_e'($urandom_range(0, 1)), ID_W'($urandom_range(0, NPROC - 1)));
    else if (depth == 0 ||
             (depth < NPROC && $urandom_range(0, 99) < (depth < target ? 75 : 25)))
      send_beat(OP_APPEND, any_free_id());
    else
      send_beat(OP_REMOVE, any_queued_id());
  endtask

  // Receiver backpressure in random bursts.
  initial begin : rx_stall
    forever begin
      @(negedge clk);
      if (!calm && stall_odds > 0 && $urandom_range(1, 100) <= stall_odds) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int target;
    target = 8;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed corners: extreme ids, only entry, head, tail, middle, errors.
    send_beat(OP_APPEND, 6'd0);
    send_beat(OP_APPEND, 6'd63);
    send_beat(OP_APPEND, 6'd63);   // duplicate append
    send_beat(OP_REMOVE, 6'd21);   // not queued
    send_beat(OP_REMOVE, 6'd0);    // head of two
    send_beat(OP_REMOVE, 6'd63);   // only entry, queue empties
    send_beat(OP_REMOVE, 6'd63);   // remove from empty queue
    send_beat(OP_APPEND, 6'd42);
    send_beat(OP_APPEND, 6'd21);
    send_beat(OP_APPEND, 6'd5);
    send_beat(OP_REMOVE, 6'd21);   // middle
    send_beat(OP_REMOVE, 6'd5);    // tail
    send_beat(OP_APPEND, 6'd63);
    send_beat(OP_REMOVE, 6'd42);   // head, one left
    send_beat(OP_REMOVE, 6'd63);   // only entry
    send_beat(OP_APPEND, 6'd1);
    send_beat(OP_APPEND, 6'd2);
    send_beat(OP_APPEND, 6'd3);
    send_beat(OP_APPEND, 6'd2);    // duplicate in the middle
    send_beat(OP_REMOVE, 6'd2);    // middle
    send_beat(OP_REMOVE, 6'd1);    // head
    send_beat(OP_REMOVE, 6'd3);    // only entry
    drain();

    // Random mixes, depth target and idling changing every 60 beats.
    for (int i = 0; i < 600; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(0, 5))
          0: target = 1;
          1: target = 2;
          2: target = 4;
          3: target = 12;
          4: target = 40;
          default: target = NPROC;
        endcase
        case ($urandom_range(0, 2))
          0: gap_odds = 0;
          1: gap_odds = 10;
          default: gap_odds = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 10;
          default: stall_odds = 40;
        endcase
      end
      random_beat(target);
    end
    drain();

    // Fill every slot, then empty in random order.
    gap_odds   = 15;
    stall_odds = 15;
    while (depth < NPROC) send_beat(OP_APPEND, any_free_id());
    send_beat(OP_APPEND, any_queued_id());
    while (depth > 0) send_beat(OP_REMOVE, any_queued_id());
    drain();

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    for (int i = 0; i < 200; i++) random_beat(20);
    drain();
    repeat (8) @(negedge clk);

    $display("Run covered %0d input beats and %0d checked results, peak depth %0d of %0d slots",
             beats, checked, peak_depth, NPROC);
    $display("Directed corner cases, random append/remove mixes, a full fill and drain, idle-free tail");
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
